// ===== design/kwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared constants, codes and controller/datapath interface types of the
// k-way sorted merge unit.
// ----------------------------------------------------------------------------
package kwsm_pkg;

  localparam int WAYS_DEF     = 32;
  localparam int DEPTH_DEF    = 1024;
  localparam int DATA_W       = 64;
  localparam int WAY_FIELD_W  = 5;
  localparam int CFG_W        = 6;
  localparam int ACT_W        = 2;
  localparam int ACTIVE_RESET = 32;
  localparam int TDATA_W      = 72;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic clear;
    logic scan_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic out_free;
  } status_t;

endpackage

// ===== design/kwsm_ram.sv =====
// ----------------------------------------------------------------------------
// kwsm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module kwsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/kwsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwsm_ctrl
// Request sequencer: decodes accepted requests and steps the datapath
// through load, clear and pop scan.
// ----------------------------------------------------------------------------
module kwsm_ctrl
  import kwsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  action_t in_action,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_LOAD: begin
              cmd.capture = 1'b1;
              state_next  = ST_LOAD_WR;
            end
            ACT_POP: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_SCAN: begin
        if (!status.scan_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/kwsm_dpath.sv =====
// ----------------------------------------------------------------------------
// kwsm_dpath
// Merge datapath: list store, per-way fill and read pointers, head scan
// pipeline with one shared comparator, and the result register.
// ----------------------------------------------------------------------------
module kwsm_dpath
  import kwsm_pkg::*;
#(
  parameter int WAYS  = WAYS_DEF,
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic [WAY_FIELD_W-1:0] in_way,
  input  logic [DATA_W-1:0]      in_value,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DATA_W-1:0]      out_value,
  output logic [WAY_FIELD_W-1:0] out_way,
  output logic                   out_done
);

  localparam int WAY_W      = $clog2(WAYS);
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W      = $clog2(WAYS + 1);
  localparam int LIST_DEPTH = WAYS * (2 ** PTR_W);

  logic [CFG_W-1:0]  active_ways;
  logic [LIM_W-1:0]  limit;

  logic [WAY_W-1:0]  load_way;
  logic              load_way_ok;
  logic [DATA_W-1:0] load_value;
  logic [FILL_W-1:0] cur_fill;
  logic              load_ok;

  logic [WAYS-1:0]   way_valid;
  logic              valid_q;
  logic [WAY_W-1:0]  meta_raddr;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] ptr_q;
  logic              ptr_we;
  logic [WAY_W-1:0]  ptr_waddr;
  logic [FILL_W-1:0] ptr_wdata;

  logic              issuing;
  logic [LIM_W-1:0]  cnt;
  logic              p1_v;
  logic [WAY_W-1:0]  p1_way;
  logic              live;
  logic              p2_v;
  logic [WAY_W-1:0]  p2_way;
  logic [FILL_W-1:0] p2_ptr;
  logic [DATA_W-1:0] list_q;

  logic              found;
  logic [DATA_W-1:0] best_value;
  logic [WAY_W-1:0]  best_way;
  logic [FILL_W-1:0] best_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ways <= CFG_W'(ACTIVE_RESET);
    end else if (cfg_we) begin
      active_ways <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(active_ways) > WAYS) begin
      limit = LIM_W'(WAYS);
    end else begin
      limit = LIM_W'(active_ways);
    end
  end

  // load capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      load_way    <= WAY_W'(in_way);
      load_way_ok <= int'(in_way) < WAYS;
      load_value  <= in_value;
    end
  end

  assign cur_fill = valid_q ? fill_q : '0;
  assign load_ok  = cmd.load_wr && load_way_ok && (cur_fill < FILL_W'(DEPTH));

  // per-way metadata
  assign meta_raddr = issuing ? cnt[WAY_W-1:0] : WAY_W'(in_way);

  always_ff @(posedge clk) begin
    if (rst) begin
      way_valid <= '0;
    end else if (cmd.clear) begin
      way_valid <= '0;
    end else if (load_ok) begin
      way_valid[load_way] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= way_valid[meta_raddr];
  end

  kwsm_ram #(
    .WIDTH (FILL_W),
    .DEPTH (WAYS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (load_way),
    .wdata (cur_fill + FILL_W'(1)),
    .raddr (meta_raddr),
    .rdata (fill_q)
  );

  always_comb begin
    ptr_we    = 1'b0;
    ptr_waddr = load_way;
    ptr_wdata = '0;
    if (cmd.finish && found) begin
      ptr_we    = 1'b1;
      ptr_waddr = best_way;
      ptr_wdata = best_ptr + FILL_W'(1);
    end else if (load_ok && !valid_q) begin
      ptr_we = 1'b1;
    end
  end

  kwsm_ram #(
    .WIDTH (FILL_W),
    .DEPTH (WAYS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (meta_raddr),
    .rdata (ptr_q)
  );

  // list store
  kwsm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr ({load_way, cur_fill[PTR_W-1:0]}),
    .wdata (load_value),
    .raddr ({p1_way, ptr_q[PTR_W-1:0]}),
    .rdata (list_q)
  );

  // head scan: issue, metadata check, compare
  assign live = p1_v && valid_q && (ptr_q < fill_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      p1_v    <= 1'b0;
      p2_v    <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        issuing <= (limit != '0);
      end else if (issuing && (cnt == limit - LIM_W'(1))) begin
        issuing <= 1'b0;
      end
      p1_v <= issuing;
      p2_v <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt <= '0;
    end else if (issuing) begin
      cnt <= cnt + LIM_W'(1);
    end
    p1_way <= cnt[WAY_W-1:0];
    p2_way <= p1_way;
    p2_ptr <= ptr_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_start) begin
      found <= 1'b0;
    end else if (p2_v && (!found || ($signed(list_q) < $signed(best_value)))) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_v && (!found || ($signed(list_q) < $signed(best_value)))) begin
      best_value <= list_q;
      best_way   <= p2_way;
      best_ptr   <= p2_ptr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value <= found ? best_value : '0;
      out_way   <= found ? WAY_FIELD_W'(best_way) : '0;
      out_done  <= !found;
    end
  end

  assign status.scan_busy = issuing || p1_v || p2_v;
  assign status.out_free  = !out_valid || out_ready;

endmodule

// ===== design/k_way_sorted_merge_unit.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit
// K-way merge of sorted lists by linear scan of the list heads.
//
// Requests arrive on the s_axis channel: tuser selects load, pop, clear or
// no-op; a load appends tdata's value to the list named by its way field.
// Loads into a full list or a way beyond WAYS are dropped. Each pop
// returns one result on m_axis: the smallest head among the first
// active_ways lists with its way number, or the done flag when all are
// exhausted. Ties go to the lowest way.
// A load is captured, then written to its list; a clear or no-op is done
// in the idle state; a pop scans min(active_ways, WAYS) ways, none when
// active_ways is zero, then writes the result register; the scan reads one
// way's pointers and head per cycle through a single pipelined port on each
// RAM and one shared 64-bit comparator. One request is in work at a time.
// Reset empties every list and sets active_ways to 32; no clearing pass.
// A stalled result holds in the output register; loads and clears are
// still taken, a further pop is taken and scanned, then holds s_axis_tready
// low until the result slot frees.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_unit
  import kwsm_pkg::*;
#(
  parameter int WAYS  = WAYS_DEF,
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,      // active_ways
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // way[4:0], value[68:5]
  input  logic [ACT_W-1:0]   s_axis_tuser,   // action[1:0]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // merged_value[63:0], source_way[68:64]
  output logic [0:0]         m_axis_tuser    // done_res[0]
);

  cmd_t                   cmd;
  status_t                status;
  logic [DATA_W-1:0]      out_value;
  logic [WAY_FIELD_W-1:0] out_way;
  logic                   out_done;

  kwsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (action_t'(s_axis_tuser)),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  kwsm_dpath #(
    .WAYS  (WAYS),
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_way    (s_axis_tdata[WAY_FIELD_W-1:0]),
    .in_value  (s_axis_tdata[WAY_FIELD_W +: DATA_W]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_way   (out_way),
    .out_done  (out_done)
  );

  assign m_axis_tdata = {(TDATA_W - DATA_W - WAY_FIELD_W)'(0), out_way, out_value};
  assign m_axis_tuser = out_done;

  a_done_is_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("done result carries a value or way");

  a_finish_slot_free : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result written over a waiting result");

  a_scan_on_pop : assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_POP))
    else $error("scan started without an accepted pop");

  a_finish_shows : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_axis_tvalid)
    else $error("finished pop gave no result");

endmodule

// ===== tb/k_way_sorted_merge_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit_test
// Self-checking testbench for the k-way sorted merge unit. A queue of
// requests (loads, pops, clears, no-ops) is played into s_axis under random
// gaps. Each accepted request updates a local copy of the lists, fill counts
// and read pointers. Every pop predicts the smallest head or the done flag,
// and the prediction is compared with the next m_axis result. Phases cover
// several active_ways settings, tie and extreme values.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_unit_test;
  import kwsm_pkg::*;

  localparam int     WAYS        = WAYS_DEF;
  localparam int     DEPTH       = DEPTH_DEF;
  localparam int     DRAIN       = 48;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam longint VAL_MIN     = 64'sh8000_0000_0000_0000;
  localparam longint VAL_MAX     = 64'sh7fff_ffff_ffff_ffff;

  typedef struct {
    action_t            action;
    logic [4:0]         way;
    logic signed [63:0] value;
  } merge_req_t;

  typedef struct {
    logic signed [63:0] merged_value;
    logic [4:0]         source_way;
    logic               done_res;
  } merge_res_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;  // way[4:0], value[68:5]
  logic [ACT_W-1:0]   s_axis_tuser = '0;  // action[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;       // merged_value[63:0], source_way[68:64]
  logic [0:0]         m_axis_tuser;       // done_res[0]

  logic signed [63:0] list_mem [WAYS][DEPTH];
  int                 fill_cnt [WAYS];
  int                 rd_ptr [WAYS];
  int                 active_cfg = ACTIVE_RESET;

  merge_req_t request_backlog[$];
  merge_res_t results_due[$];
  merge_req_t req_out;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         items_queued = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  k_way_sorted_merge_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int w = 0; w < WAYS; w++) begin
      fill_cnt[w] = 0;
      rd_ptr[w]   = 0;
    end
  end

  function automatic void merge_step(merge_req_t r);
    int                 span;
    bit                 found;
    int                 best_way;
    logic signed [63:0] best;
    merge_res_t         res;
    found    = 1'b0;
    best_way = 0;
    best     = '0;
    case (r.action)
      ACT_LOAD: begin
        if (fill_cnt[r.way] < DEPTH) begin
          list_mem[r.way][fill_cnt[r.way]] = r.value;
          fill_cnt[r.way]++;
        end
      end
      ACT_CLEAR: begin
        for (int w = 0; w < WAYS; w++) begin
          fill_cnt[w] = 0;
          rd_ptr[w]   = 0;
        end
      end
      ACT_POP: begin
        span = (active_cfg > WAYS) ? WAYS : active_cfg;
        for (int w = 0; w < span; w++) begin
          if (rd_ptr[w] < fill_cnt[w] && (!found || list_mem[w][rd_ptr[w]] < best)) begin
            found    = 1'b1;
            best     = list_mem[w][rd_ptr[w]];
            best_way = w;
          end
        end
        if (found) begin
          rd_ptr[best_way]++;
          res.merged_value = best;
          res.source_way   = best_way[4:0];
          res.done_res     = 1'b0;
        end else begin
          res.merged_value = '0;
          res.source_way   = '0;
          res.done_res     = 1'b1;
        end
        results_due.insert(results_due.size(), res);
      end
      default: ;
    endcase
  endfunction

  // hold the request until taken, then predict and advance
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid)
        merge_step(req_out);
      if (request_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        req_out = request_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, req_out.value, req_out.way};
        s_axis_tuser  <= req_out.action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_merge_result();
    merge_res_t want;
    if (results_due.size() == 0) begin
      $error("merge result with no pop waiting: merged_value %0d",
             $signed(m_axis_tdata[63:0]));
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    if (m_axis_tdata[63:0] !== want.merged_value) begin
      $error("merged_value: expected %0d, got %0d", want.merged_value,
             $signed(m_axis_tdata[63:0]));
      mismatches++;
    end
    if (m_axis_tdata[68:64] !== want.source_way) begin
      $error("source_way: expected %0d, got %0d", want.source_way, m_axis_tdata[68:64]);
      mismatches++;
    end
    if (m_axis_tuser[0] !== want.done_res) begin
      $error("done_res: expected %0d, got %0d", want.done_res, m_axis_tuser[0]);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_merge_result();
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic queue_req(input action_t act, input logic [4:0] way, input longint value);
    merge_req_t r;
    r.action = act;
    r.way    = way;
    r.value  = value;
    request_backlog.insert(request_backlog.size(), r);
    if (act != ACT_NOP)
      items_queued++;
  endtask

  function automatic longint rand_value(input int style);
    int small_val;
    small_val = $urandom_range(0, 6);
    case (style)
      0: return {$urandom, $urandom};
      1: return small_val - 3;
      default: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return small_val - 3;
          default: return {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  function automatic int pick_way();
    int span;
    span = (active_cfg > WAYS) ? WAYS : active_cfg;
    if (span > 0 && $urandom_range(99, 0) < 80)
      return $urandom_range(0, span - 1);
    return $urandom_range(0, WAYS - 1);
  endfunction

  task automatic queue_noise();
    queue_req(action_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), rand_value(0));
  endtask

  // sorted lists spread over a few ways, loads interleaved, then pop past done; or eight random requests
  task automatic queue_merge_round();
    longint lists [6][$];
    int     ways [6];
    int     taken [6];
    int     nlists;
    int     style;
    int     total;
    int     k;
    if ($urandom_range(99, 0) < 10) begin
      repeat (8) queue_noise();
      return;
    end
    if ($urandom_range(99, 0) < 80)
      queue_req(ACT_CLEAR, 5'($urandom_range(0, 31)), rand_value(0));
    style  = $urandom_range(0, 2);
    nlists = $urandom_range(1, 6);
    total  = 0;
    for (int i = 0; i < nlists; i++) begin
      ways[i]  = pick_way();
      taken[i] = 0;
      repeat ($urandom_range(0, 5)) lists[i].insert(lists[i].size(), rand_value(style));
      lists[i].sort();
      total += lists[i].size();
    end
    for (int i = 0; i < total; i++) begin
      do k = $urandom_range(0, nlists - 1); while (taken[k] >= lists[k].size());
      queue_req(ACT_LOAD, ways[k][4:0], lists[k][taken[k]]);
      taken[k]++;
    end
    repeat (total + $urandom_range(1, 2)) begin
      if ($urandom_range(99, 0) < 10)
        queue_noise();
      queue_req(ACT_POP, 5'($urandom_range(0, 31)), rand_value(0));
    end
  endtask

  task automatic wait_quiet();
    while (request_backlog.size() != 0 || s_axis_tvalid || results_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_active(input int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_cfg = v;
    @(negedge clk);
  endtask

  initial begin
    int active_plan [6];
    int phase_items [6];
    int budget;
    active_plan = '{1, 0, $urandom_range(2, 31), 63, 32, $urandom_range(2, 31)};
    phase_items = '{80, 30, 80, 80, 90, 80};
    send_idle_pct = 28;
    recv_idle_pct = 83;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pop, extremes, ties, load after pops, unsorted, clear
    queue_req(ACT_POP, 5'd31, VAL_MAX);
    queue_req(ACT_LOAD, 5'd0, VAL_MAX);
    queue_req(ACT_LOAD, 5'd31, VAL_MIN);
    queue_req(ACT_LOAD, 5'd5, -1);
    queue_req(ACT_LOAD, 5'd5, 0);
    queue_req(ACT_LOAD, 5'd3, 0);
    queue_req(ACT_NOP, 5'd31, VAL_MIN);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_LOAD, 5'd5, 1);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_LOAD, 5'd7, 100);
    queue_req(ACT_LOAD, 5'd7, 50);
    queue_req(ACT_LOAD, 5'd2, 75);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_CLEAR, 5'd0, 0);
    queue_req(ACT_POP, 5'd0, 0);
    queue_req(ACT_LOAD, 5'd9, 2);
    queue_req(ACT_POP, 5'd0, 0);
    wait_quiet();

    items_queued = 0;
    budget       = 0;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 83;
        recv_idle_pct = 28;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_active(active_plan[phase]);
      budget += phase_items[phase];
      while (items_queued < budget)
        queue_merge_round();
      wait_quiet();
    end

    if (mismatches == 0 && results_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
